>>> hw/rtl/lsmt_pkg.sv
// ----------------------------------------------------------------------------
// lsmt_pkg: shared types and constants for the lcd scanline mode timing block
// Line geometry, mode codes, command codes, register map and bundle types.
// ----------------------------------------------------------------------------
package lsmt_pkg;

  // line and frame geometry
  localparam logic [9:0] DOTS_PER_LINE   = 10'd456;
  localparam logic [8:0] LINES_PER_FRAME = 9'd154;
  localparam logic [7:0] VISIBLE_LINES   = 8'd144;
  localparam logic [8:0] OAM_DOTS        = 9'd80;
  localparam logic [8:0] DOT_MAX         = 9'h1FF;

  // register map, indexed by paddr[2]
  localparam int unsigned PADDR_W = 3;
  localparam logic REG_LINE_COMPARE = 1'b0;
  localparam logic REG_STAT_SEL     = 1'b1;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_LINE_RST = 2'd1,
    CMD_DISP_OFF = 2'd2,
    CMD_DISP_ON  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    PH_HBLANK = 4'b0001,
    PH_VBLANK = 4'b0010,
    PH_OAM    = 4'b0100,
    PH_XFER   = 4'b1000
  } phase_e;

  // stat_sel bit positions
  localparam int unsigned SEL_HBLANK  = 0;
  localparam int unsigned SEL_VBLANK  = 1;
  localparam int unsigned SEL_OAM     = 2;
  localparam int unsigned SEL_COMPARE = 3;

  typedef struct packed {
    logic [7:0] line_compare;
    logic [3:0] stat_sel;
  } cfg_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] line;
    logic [7:0] status_byte;
    logic [8:0] dot;
    logic       vblank_irq;
    logic       stat_irq;
    logic       line_end;
    logic       frame_start;
    logic       transfer_start;
  } result_t;

endpackage

>>> hw/rtl/lsmt_cfg.sv
// ----------------------------------------------------------------------------
// lsmt_cfg: apb register file
// Holds line_compare and the status interrupt select bits; zero wait states.
// ----------------------------------------------------------------------------
module lsmt_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lsmt_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output lsmt_pkg::cfg_t                 cfg_o
);

  logic [7:0] line_compare_q, line_compare_d;
  logic [3:0] stat_sel_q, stat_sel_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    line_compare_d = line_compare_q;
    stat_sel_d     = stat_sel_q;
    if (wr_en) begin
      unique case (paddr[2])
        lsmt_pkg::REG_LINE_COMPARE: line_compare_d = pwdata[7:0];
        lsmt_pkg::REG_STAT_SEL:     stat_sel_d     = pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      lsmt_pkg::REG_LINE_COMPARE: prdata = {24'd0, line_compare_q};
      lsmt_pkg::REG_STAT_SEL:     prdata = {28'd0, stat_sel_q};
      default:                    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_compare_q <= 8'd0;
      stat_sel_q     <= 4'd0;
    end else begin
      line_compare_q <= line_compare_d;
      stat_sel_q     <= stat_sel_d;
    end
  end

  assign cfg_o.line_compare = line_compare_q;
  assign cfg_o.stat_sel     = stat_sel_q;

endmodule

>>> hw/rtl/lsmt_seq.sv
// ----------------------------------------------------------------------------
// lsmt_seq: mode sequencer with dot and line counters
// Advances the timing state by one tick or command per step and forms the
// result for that step.
// ----------------------------------------------------------------------------
module lsmt_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  lsmt_pkg::cmd_e       cmd_i,
  input  logic                 line_done_i,
  input  lsmt_pkg::cfg_t       cfg_i,
  output lsmt_pkg::result_t    result_o
);

  lsmt_pkg::phase_e phase_q, phase_d;
  lsmt_pkg::mode_e  mode_q, mode_d;
  logic             flag_q, flag_d;
  logic [7:0]       line_q, line_d;
  logic [8:0]       dot_q, dot_d;
  logic             on_q, on_d;

  logic [9:0] dot_inc;
  logic [8:0] dot_wrap;
  logic [8:0] line_inc;
  logic [7:0] line_wrap;
  logic       line_hit;
  logic       vblank_irq, stat_irq, line_end, frame_start, transfer_start;

  // counters never exceed twice their modulus, so one subtract wraps them
  assign dot_inc   = {1'b0, dot_q} + 10'd1;
  assign dot_wrap  = (dot_inc >= lsmt_pkg::DOTS_PER_LINE)
                     ? 9'(dot_inc - lsmt_pkg::DOTS_PER_LINE) : dot_inc[8:0];
  assign line_inc  = {1'b0, line_q} + 9'd1;
  assign line_wrap = (line_inc >= lsmt_pkg::LINES_PER_FRAME)
                     ? 8'(line_inc - lsmt_pkg::LINES_PER_FRAME) : line_inc[7:0];
  assign line_hit  = (line_wrap == cfg_i.line_compare);

  always_comb begin
    phase_d        = phase_q;
    mode_d         = mode_q;
    flag_d         = flag_q;
    line_d         = line_q;
    dot_d          = dot_q;
    on_d           = on_q;
    vblank_irq     = 1'b0;
    stat_irq       = 1'b0;
    line_end       = 1'b0;
    frame_start    = 1'b0;
    transfer_start = 1'b0;

    unique case (cmd_i)
      lsmt_pkg::CMD_LINE_RST: begin
        line_d = 8'd0;
      end
      lsmt_pkg::CMD_DISP_OFF: begin
        dot_d   = 9'd0;
        line_d  = 8'd0;
        mode_d  = lsmt_pkg::MODE_HBLANK;
        phase_d = lsmt_pkg::PH_VBLANK;
        on_d    = 1'b0;
      end
      lsmt_pkg::CMD_DISP_ON: begin
        on_d = 1'b1;
      end
      default: begin
        if (on_q) begin
          unique case (phase_q)
            lsmt_pkg::PH_HBLANK: begin
              dot_d = dot_wrap;
              if (dot_wrap == 9'd0) begin
                line_end = 1'b1;
                line_d   = line_wrap;
                flag_d   = line_hit;
                if (line_hit && cfg_i.stat_sel[lsmt_pkg::SEL_COMPARE]) stat_irq = 1'b1;
                if (line_wrap == lsmt_pkg::VISIBLE_LINES) begin
                  phase_d    = lsmt_pkg::PH_VBLANK;
                  mode_d     = lsmt_pkg::MODE_VBLANK;
                  vblank_irq = 1'b1;
                  if (cfg_i.stat_sel[lsmt_pkg::SEL_VBLANK]) stat_irq = 1'b1;
                end else begin
                  phase_d = lsmt_pkg::PH_OAM;
                  mode_d  = lsmt_pkg::MODE_OAM;
                  if (cfg_i.stat_sel[lsmt_pkg::SEL_OAM]) stat_irq = 1'b1;
                end
              end
            end
            lsmt_pkg::PH_VBLANK: begin
              dot_d = dot_wrap;
              if (dot_wrap == 9'd0) begin
                line_d = line_wrap;
                flag_d = line_hit;
                if (line_hit && cfg_i.stat_sel[lsmt_pkg::SEL_COMPARE]) stat_irq = 1'b1;
                if (line_wrap == 8'd0) begin
                  frame_start = 1'b1;
                  phase_d     = lsmt_pkg::PH_OAM;
                  mode_d      = lsmt_pkg::MODE_OAM;
                  if (cfg_i.stat_sel[lsmt_pkg::SEL_OAM]) stat_irq = 1'b1;
                end
              end
            end
            lsmt_pkg::PH_XFER: begin
              // transfer entry has no enable bit, hblank entry does
              if (line_done_i) begin
                phase_d = lsmt_pkg::PH_HBLANK;
                mode_d  = lsmt_pkg::MODE_HBLANK;
                if (cfg_i.stat_sel[lsmt_pkg::SEL_HBLANK]) stat_irq = 1'b1;
              end
              // saturating count during a long transfer
              if (dot_q != lsmt_pkg::DOT_MAX) dot_d = dot_inc[8:0];
            end
            lsmt_pkg::PH_OAM: begin
              dot_d = dot_wrap;
              if (dot_wrap == lsmt_pkg::OAM_DOTS) begin
                transfer_start = 1'b1;
                phase_d        = lsmt_pkg::PH_XFER;
                mode_d         = lsmt_pkg::MODE_XFER;
              end
            end
            default: ;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lsmt_pkg::PH_OAM;
      mode_q  <= lsmt_pkg::MODE_VBLANK;
      flag_q  <= 1'b0;
      line_q  <= 8'd0;
      dot_q   <= 9'd0;
      on_q    <= 1'b1;
    end else if (step_i) begin
      phase_q <= phase_d;
      mode_q  <= mode_d;
      flag_q  <= flag_d;
      line_q  <= line_d;
      dot_q   <= dot_d;
      on_q    <= on_d;
    end
  end

  assign result_o.mode           = mode_d;
  assign result_o.line           = line_d;
  assign result_o.status_byte    = {1'b1, cfg_i.stat_sel, flag_d, mode_d};
  assign result_o.dot            = dot_d;
  assign result_o.vblank_irq     = vblank_irq;
  assign result_o.stat_irq       = stat_irq;
  assign result_o.line_end       = line_end;
  assign result_o.frame_start    = frame_start;
  assign result_o.transfer_start = transfer_start;

endmodule

>>> hw/rtl/lcd_scanline_mode_timing.sv
// ----------------------------------------------------------------------------
// lcd_scanline_mode_timing: lcd controller mode and scanline timing
// Sequences oam search, pixel transfer, hblank and vblank per dot tick.
// ----------------------------------------------------------------------------
// Usage:
//   input channel (in_valid_i / in_stall_o) carries one dot tick or command
//   per transfer: cmd_i and line_done_i from the renderer.
//   output channel (out_valid_o / out_stall_i) returns one result per input
//   transfer: mode, line, status byte, dot count and event pulses.
//   each result passes the input register, then the result register; one
//   item is taken every cycle while the receiver does not stall.
//   when the receiver stalls, the result register holds; the input register
//   keeps or takes one transfer, and in_stall_o is raised while it holds one.
//   the apb port writes line_compare (0x0) and stat_int_select (0x4); write
//   them only while no transfer is in flight.
//   reset: oam search phase, mode bits 1, line 0, dot 0, display on,
//   compare flag 0, both registers 0, both channels empty.
// ----------------------------------------------------------------------------
module lcd_scanline_mode_timing (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   cmd_i,
  input  logic                         line_done_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   mode_o,
  output logic [7:0]                   line_o,
  output logic [7:0]                   status_byte_o,
  output logic [8:0]                   dot_o,
  output logic                         vblank_irq_o,
  output logic                         stat_irq_o,
  output logic                         line_end_o,
  output logic                         frame_start_o,
  output logic                         transfer_start_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lsmt_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic              in_valid_q;
  lsmt_pkg::cmd_e    cmd_q;
  logic              done_q;
  logic              out_valid_q;
  lsmt_pkg::result_t result_q, result_d;
  lsmt_pkg::cfg_t    cfg;
  logic              out_free;
  logic              step;

  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign step       = in_valid_q & out_free;
  assign in_stall_o = in_valid_q & ~out_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      cmd_q  <= lsmt_pkg::cmd_e'(cmd_i);
      done_q <= line_done_i;
    end
  end

  lsmt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lsmt_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .cmd_i       (cmd_q),
    .line_done_i (done_q),
    .cfg_i       (cfg),
    .result_o    (result_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign mode_o           = result_q.mode;
  assign line_o           = result_q.line;
  assign status_byte_o    = result_q.status_byte;
  assign dot_o            = result_q.dot;
  assign vblank_irq_o     = result_q.vblank_irq;
  assign stat_irq_o       = result_q.stat_irq;
  assign line_end_o       = result_q.line_end;
  assign frame_start_o    = result_q.frame_start;
  assign transfer_start_o = result_q.transfer_start;

endmodule
